FILE: rtl/brfd_pkg.sv
// Shared types and constants for the byte ring FIFO with delimiter detection.
package brfd_pkg;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_POPWORD = 2'd2,
    OP_COUNT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_EMPTY = 2'd0,
    MODE_DATA  = 2'd1,
    MODE_FULL  = 2'd2
  } fill_mode_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_EMIT = 2'd2
  } state_t;

  localparam logic [7:0] DELIM_RESET = 8'h3B;
  localparam logic [2:0] WORD_BYTES  = 3'd4;

endpackage

FILE: rtl/brfd_ram.sv
// Byte store: one write port, one read port, registered read data.
module brfd_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/byte_ring_fifo_with_delimiter.sv
// Byte ring FIFO with delimiter flag: sequencer, index/fill state and result register.
// Push and count finish in the cycle they are accepted; pop and pop-word read the byte
//   store from S_IDLE and S_READ, one byte read per cycle, and finish in S_READ (a pop
//   on an empty ring finishes at once with an error). Results go to the output register.
// Requests are taken only in S_IDLE, so none is accepted during S_READ or S_EMIT.
// Reset (rst, synchronous): indices zero, ring empty, delimiter 0x3B, no result pending.
//   The byte store is not cleared; no clearing pass.
module byte_ring_fifo_with_delimiter #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  push_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        error_flag,
  output logic [31:0] read_data,
  output logic [2:0]  bytes_read,
  output logic [8:0]  occupancy,
  output logic        delimiter_seen,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import brfd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

  state_t     state, state_next;
  fill_mode_t fill_mode, fill_mode_next;
  logic [AW-1:0] wr_idx, wr_idx_next, rd_idx, rd_idx_next;
  logic [7:0] delim;
  logic [2:0] tgt, tgt_next;
  logic [1:0] got, got_next;
  logic [31:0] word, word_next, word_cur;
  logic is_word, is_word_next;

  logic res_err, res_err_next, res_delim, res_delim_next;
  logic [31:0] res_data, res_data_next;
  logic [2:0] res_nread, res_nread_next;
  logic [8:0] res_occ, res_occ_next;

  logic out_valid_next, out_err_next, out_delim_next;
  logic [31:0] out_data_next;
  logic [2:0] out_nread_next;
  logic [8:0] out_occ_next;

  logic fin, fin_err, fin_delim;
  logic [31:0] fin_data;
  logic [2:0] fin_nread;
  logic [8:0] fin_occ;
  logic out_free, accept;
  logic [AW:0] fill_now;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0] ram_rdata;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW:0] fill_of(input logic [AW-1:0] w, input logic [AW-1:0] r,
                                          input fill_mode_t m);
    logic [AW:0] d;
    d = {1'b0, w} - {1'b0, r};
    if (w < r) begin
      d = d + DEPTH_W;
    end
    if (m == MODE_FULL) begin
      d = DEPTH_W;
    end
    return d;
  endfunction

  brfd_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (push_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign fill_now = fill_of(wr_idx, rd_idx, fill_mode);

  always_comb begin
    case (got)
      2'd0:    word_cur = {word[31:8], ram_rdata};
      2'd1:    word_cur = {word[31:16], ram_rdata, word[7:0]};
      2'd2:    word_cur = {word[31:24], ram_rdata, word[15:0]};
      default: word_cur = {ram_rdata, word[23:0]};
    endcase
  end

  always_comb begin
    state_next     = state;
    fill_mode_next = fill_mode;
    wr_idx_next    = wr_idx;
    rd_idx_next    = rd_idx;
    tgt_next       = tgt;
    got_next       = got;
    word_next      = word;
    is_word_next   = is_word;
    ram_we         = 1'b0;
    ram_waddr      = wr_idx;
    ram_re         = 1'b0;
    ram_raddr      = rd_idx;
    fin            = 1'b0;
    fin_err        = 1'b0;
    fin_delim      = 1'b0;
    fin_data       = '0;
    fin_nread      = '0;
    fin_occ        = 9'(fill_now);

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(operation))
            OP_PUSH: begin
              fin       = 1'b1;
              fin_delim = (push_byte == delim);
              if (fill_mode != MODE_FULL) begin
                ram_we      = 1'b1;
                wr_idx_next = inc(wr_idx);
                if (fill_mode == MODE_EMPTY) begin
                  fill_mode_next = MODE_DATA;
                end else if (inc(wr_idx) == rd_idx) begin
                  fill_mode_next = MODE_FULL;
                end
              end else begin
                fin_err = 1'b1;
              end
              fin_occ = 9'(fill_of(wr_idx_next, rd_idx, fill_mode_next));
            end
            OP_POP, OP_POPWORD: begin
              if (fill_mode == MODE_EMPTY) begin
                fin     = 1'b1;
                fin_err = 1'b1;
              end else begin
                ram_re       = 1'b1;
                rd_idx_next  = inc(rd_idx);
                fill_mode_next = (fill_mode == MODE_FULL) ? MODE_DATA :
                                 (wr_idx == inc(rd_idx)) ? MODE_EMPTY : MODE_DATA;
                is_word_next = (op_t'(operation) == OP_POPWORD);
                if (op_t'(operation) == OP_POP) begin
                  tgt_next = 3'd1;
                end else if (fill_now > (AW+1)'(3)) begin
                  tgt_next = WORD_BYTES;
                end else begin
                  tgt_next = 3'(fill_now);
                end
                got_next   = '0;
                word_next  = '0;
                state_next = S_READ;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (3'(got) + 3'd1 < tgt) begin
          ram_re         = 1'b1;
          rd_idx_next    = inc(rd_idx);
          fill_mode_next = (fill_mode == MODE_FULL) ? MODE_DATA :
                           (wr_idx == inc(rd_idx)) ? MODE_EMPTY : MODE_DATA;
          got_next       = got + 2'd1;
          word_next      = word_cur;
        end else begin
          fin        = 1'b1;
          fin_data   = word_cur;
          fin_nread  = tgt;
          fin_err    = is_word && (tgt < WORD_BYTES);
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_err_next   = res_err;
    res_data_next  = res_data;
    res_nread_next = res_nread;
    res_occ_next   = res_occ;
    res_delim_next = res_delim;
    out_valid_next = out_valid && !out_ready;
    out_err_next   = error_flag;
    out_data_next  = read_data;
    out_nread_next = bytes_read;
    out_occ_next   = occupancy;
    out_delim_next = delimiter_seen;
    if (state == S_EMIT && out_free) begin
      out_valid_next = 1'b1;
      out_err_next   = res_err;
      out_data_next  = res_data;
      out_nread_next = res_nread;
      out_occ_next   = res_occ;
      out_delim_next = res_delim;
    end else if (fin && out_free) begin
      out_valid_next = 1'b1;
      out_err_next   = fin_err;
      out_data_next  = fin_data;
      out_nread_next = fin_nread;
      out_occ_next   = fin_occ;
      out_delim_next = fin_delim;
    end else if (fin) begin
      res_err_next   = fin_err;
      res_data_next  = fin_data;
      res_nread_next = fin_nread;
      res_occ_next   = fin_occ;
      res_delim_next = fin_delim;
    end
  end

  // result parked when the output register is still occupied
  logic park;
  assign park = fin && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill_mode <= MODE_EMPTY;
      wr_idx    <= '0;
      rd_idx    <= '0;
      delim     <= DELIM_RESET;
      out_valid <= 1'b0;
    end else begin
      state     <= park ? S_EMIT : state_next;
      fill_mode <= fill_mode_next;
      wr_idx    <= wr_idx_next;
      rd_idx    <= rd_idx_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        delim <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    tgt            <= tgt_next;
    got            <= got_next;
    word           <= word_next;
    is_word        <= is_word_next;
    res_err        <= res_err_next;
    res_data       <= res_data_next;
    res_nread      <= res_nread_next;
    res_occ        <= res_occ_next;
    res_delim      <= res_delim_next;
    error_flag     <= out_err_next;
    read_data      <= out_data_next;
    bytes_read     <= out_nread_next;
    occupancy      <= out_occ_next;
    delimiter_seen <= out_delim_next;
  end

endmodule

FILE: rtl/brfd_checker.sv
// Port-level assertions for the byte ring FIFO, bound to the top level.
module brfd_checker #(
  parameter int DEPTH = 256
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        error_flag,
  input logic [31:0] read_data,
  input logic [2:0]  bytes_read,
  input logic [8:0]  occupancy,
  input logic        delimiter_seen
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(occupancy))
    else $error("result beat changed while stalled");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH > 511) || (occupancy <= 9'(DEPTH)))
    else $error("occupancy above depth");

  a_delim_push: assert property (@(posedge clk) disable iff (rst)
    out_valid && delimiter_seen |-> bytes_read == 3'd0 && read_data == 32'd0)
    else $error("delimiter flagged on a pop");

  a_nothing_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && bytes_read == 3'd0 |-> read_data == 32'd0)
    else $error("data without bytes read");

  a_full_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && bytes_read == 3'd4 |-> !error_flag && bytes_read != 3'd5)
    else $error("error on a full word");

endmodule

bind byte_ring_fifo_with_delimiter brfd_checker #(.DEPTH(DEPTH)) u_brfd_checker (.*);
